// ----- rtl/core/srcl_pkg.sv -----
// Shared types and constants of the segment rectangle clipper.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package srcl_pkg;

   localparam int COORD_W   = 32;   // Q16.16 coordinate
   localparam int DIFF_W    = 33;   // difference of two coordinates
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int DIV_STEPS = 40;   // quotient bits below the saturation limit
   localparam int SUM_W     = COORD_W + 11;
   localparam int ADDR_W    = 4;

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_LEFT   = 2'd0,
      REG_RIGHT  = 2'd1,
      REG_BOTTOM = 2'd2,
      REG_TOP    = 2'd3
   } reg_idx_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type left;
      coord_type right;
      coord_type bottom;
      coord_type top;
   } win_type;

   // One segment in flight. "in" is the anchor end, "out" the end being moved.
   typedef struct packed {
      coord_type p_x;
      coord_type p_y;
      coord_type q_x;
      coord_type q_y;
      coord_type in_x;
      coord_type in_y;
      coord_type out_x;
      coord_type out_y;
      logic      swap;       // out is the first end
      logic      rej;
      logic      act;        // the current move step applies
      logic      both_out;
   } item_type;

   typedef struct packed {
      logic      visible;
      coord_type clip_start_x;
      coord_type clip_start_y;
      coord_type clip_end_x;
      coord_type clip_end_y;
   } rsp_word_type;

   function automatic logic is_inside(coord_type x, coord_type y, win_type w);
      return (x >= w.left) && (x <= w.right) && (y >= w.bottom) && (y <= w.top);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/srcl_req_if.sv -----
// Request channel of the segment clipper: one segment per word.
// Depends on srcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srcl_req_if;
   import srcl_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srcl_rsp_if.sv -----
// Response channel of the segment clipper: one clipped segment per word.
// Depends on srcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srcl_rsp_if;
   import srcl_pkg::*;

   logic      valid;
   logic      ready;
   logic      visible;
   coord_type clip_start_x;
   coord_type clip_start_y;
   coord_type clip_end_x;
   coord_type clip_end_y;

   modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, input ready);
   modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srcl_cut.sv -----
// Pipelined cut of one segment end against one window edge pair:
// base + trunc(a * b / d), saturated. Multiply in two stages, then a
// restoring divider with one quotient bit per stage. Depends on srcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srcl_cut (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               y_step,
   input  srcl_pkg::win_type  win,
   input  logic               in_v,
   input  srcl_pkg::item_type in_item,
   output logic               out_v,
   output srcl_pkg::item_type out_item
);
   import srcl_pkg::*;

   localparam int PL_W = DIFF_W + 17;
   localparam int PH_W = DIFF_W + DIFF_W - 17;
   localparam logic [DIV_STEPS:0] Q_LIMIT = {1'b1, {DIV_STEPS{1'b0}}};

   typedef struct packed {
      item_type          item;
      logic              cond;
      coord_type         edge_c;
      coord_type         base;
      logic [DIFF_W-1:0] md;
      logic              neg;
   } hdr_type;

   typedef struct packed {
      hdr_type              hdr;
      logic [DIFF_W-1:0]    rem;
      logic [DIV_STEPS-1:0] plow;
      logic [DIV_STEPS-1:0] quo;
      logic                 big;
   } div_type;

   function automatic logic [DIFF_W-1:0] mag(logic signed [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   // ---------------- setup stage ----------------
   coord_type                in_a, in_b, out_a, out_b, w_lo, w_hi;
   logic                     lo_hit, hi_hit;
   coord_type                edge_sel;
   logic signed [DIFF_W-1:0] sa, sb, sd;
   hdr_type                  s0_in;

   always_comb begin
      if (y_step) begin
         in_a  = in_item.in_y;
         out_a = in_item.out_y;
         in_b  = in_item.in_x;
         out_b = in_item.out_x;
         w_lo  = win.bottom;
         w_hi  = win.top;
      end else begin
         in_a  = in_item.in_x;
         out_a = in_item.out_x;
         in_b  = in_item.in_y;
         out_b = in_item.out_y;
         w_lo  = win.left;
         w_hi  = win.right;
      end
      lo_hit   = out_a < w_lo;
      hi_hit   = out_a > w_hi;
      edge_sel = lo_hit ? w_lo : w_hi;
      sa = {edge_sel[COORD_W-1], edge_sel} - {in_a[COORD_W-1], in_a};
      sb = {out_b[COORD_W-1], out_b} - {in_b[COORD_W-1], in_b};
      sd = {out_a[COORD_W-1], out_a} - {in_a[COORD_W-1], in_a};
      s0_in.item   = in_item;
      s0_in.cond   = in_item.act & ~in_item.rej & (lo_hit | hi_hit);
      s0_in.edge_c = edge_sel;
      s0_in.base   = in_b;
      s0_in.md     = mag(sd);
      s0_in.neg    = sa[DIFF_W-1] ^ sb[DIFF_W-1] ^ sd[DIFF_W-1];
   end

   logic              s0_v_ff, s1_v_ff, s2_v_ff;
   hdr_type           s0_ff, s1_ff, s2_ff;
   logic [DIFF_W-1:0] s0_ma_ff, s0_mb_ff;
   logic [PL_W-1:0]   s1_pl_ff;
   logic [PH_W-1:0]   s1_ph_ff;
   logic [PROD_W-1:0] s2_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= in_v;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
   end

   // The 33 x 33 product is split into two partial products on the b operand.
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff      <= s0_in;
         s0_ma_ff   <= mag(sa);
         s0_mb_ff   <= mag(sb);
         s1_ff      <= s0_ff;
         s1_pl_ff   <= PL_W'(s0_ma_ff) * PL_W'(s0_mb_ff[16:0]);
         s1_ph_ff   <= PH_W'(s0_ma_ff) * PH_W'(s0_mb_ff[DIFF_W-1:17]);
         s2_ff      <= s1_ff;
         s2_prod_ff <= {{(PROD_W-PL_W){1'b0}}, s1_pl_ff} + {s1_ph_ff, 17'b0};
      end
   end

   // ---------------- divider stages ----------------
   logic    dv_ff [0:DIV_STEPS];
   div_type dd_ff [0:DIV_STEPS];
   div_type d0_in;

   always_comb begin
      d0_in.hdr  = s2_ff;
      d0_in.rem  = DIFF_W'(s2_prod_ff[PROD_W-1:DIV_STEPS]);
      d0_in.plow = s2_prod_ff[DIV_STEPS-1:0];
      d0_in.quo  = '0;
      // The quotient reaches the limit exactly when the high part is not below d.
      d0_in.big  = DIFF_W'(s2_prod_ff[PROD_W-1:DIV_STEPS]) >= s2_ff.md;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dd_ff[0] <= d0_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [DIFF_W:0] trial;
      logic            fits;
      div_type         nxt;

      always_comb begin
         trial    = {dd_ff[k].rem, dd_ff[k].plow[DIV_STEPS-1]};
         fits     = trial >= {1'b0, dd_ff[k].hdr.md};
         nxt      = dd_ff[k];
         nxt.rem  = fits ? DIFF_W'(trial - {1'b0, dd_ff[k].hdr.md}) : DIFF_W'(trial);
         nxt.plow = {dd_ff[k].plow[DIV_STEPS-2:0], 1'b0};
         nxt.quo  = {dd_ff[k].quo[DIV_STEPS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dd_ff[k+1] <= nxt;
         end
      end
   end

   // ---------------- sign, add and saturate ----------------
   div_type                 dl;
   logic [DIV_STEPS:0]      qv;
   logic signed [SUM_W-1:0] sq, sum;
   coord_type               sat;
   item_type                fin;

   always_comb begin
      dl = dd_ff[DIV_STEPS];
      if (dl.hdr.md == '0) begin
         qv = '0;
      end else if (dl.big) begin
         qv = Q_LIMIT;
      end else begin
         qv = {1'b0, dl.quo};
      end
      sq  = dl.hdr.neg ? -SUM_W'(qv) : SUM_W'(qv);
      sum = {{(SUM_W-COORD_W){dl.hdr.base[COORD_W-1]}}, dl.hdr.base} + sq;
      if (!sum[SUM_W-1] && (sum[SUM_W-2:COORD_W-1] != '0)) begin
         sat = COORD_MAX;
      end else if (sum[SUM_W-1] && (sum[SUM_W-2:COORD_W-1] != '1)) begin
         sat = COORD_MIN;
      end else begin
         sat = sum[COORD_W-1:0];
      end
      fin = dl.hdr.item;
      if (dl.hdr.cond) begin
         if (y_step) begin
            fin.out_x = sat;
            fin.out_y = dl.hdr.edge_c;
         end else begin
            fin.out_x = dl.hdr.edge_c;
            fin.out_y = sat;
         end
      end
   end

   logic     out_v_ff;
   item_type out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_item_ff <= fin;
      end
   end

   assign out_v    = out_v_ff;
   assign out_item = out_item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/segment_rect_clipper_top.sv -----
// Top level of the segment rectangle clipper: window registers, end
// classification, four pipelined cut units and the output skid stage.
// Depends on srcl_pkg, srcl_req_if, srcl_rsp_if and srcl_cut.
//
//   port     | direction | carries
//   ---------+-----------+------------------------------------------
//   req      | in        | segment word: start_x/y, end_x/y
//   rsp      | out       | result word: visible, clipped ends
//   p* (APB) | in/out    | window_left/right/bottom/top at 0x0..0xC
//
// One word enters per cycle while the skid register is empty; a result
// passes the four cut units of 45 stages each (two multiply stages, a
// 40-stage restoring divider) plus entry, middle and output registers.
// A stalled result is parked in a one-word skid register; the pipeline
// freezes only while that register is full. Reset is synchronous and
// clears all valid bits and the window registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module segment_rect_clipper_top (
   input  logic                        clock,
   input  logic                        reset,
   srcl_req_if.sink                    req,
   srcl_rsp_if.source                  rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [srcl_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import srcl_pkg::*;

   // ---------------- window registers ----------------
   win_type     win_ff;
   reg_idx_type reg_idx;

   assign reg_idx = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_LEFT:   win_ff.left   <= pwdata;
            REG_RIGHT:  win_ff.right  <= pwdata;
            REG_BOTTOM: win_ff.bottom <= pwdata;
            REG_TOP:    win_ff.top    <= pwdata;
            default:    win_ff        <= win_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LEFT:   prdata = win_ff.left;
         REG_RIGHT:  prdata = win_ff.right;
         REG_BOTTOM: prdata = win_ff.bottom;
         REG_TOP:    prdata = win_ff.top;
         default:    prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic         skid_v_ff;
   rsp_word_type skid_ff;
   logic         adv;

   assign adv       = ~skid_v_ff;
   assign req.ready = adv;

   // ---------------- entry: classify the two ends ----------------
   item_type e_in;
   logic     p_in, q_in;

   always_comb begin
      p_in         = is_inside(req.start_x, req.start_y, win_ff);
      q_in         = is_inside(req.end_x, req.end_y, win_ff);
      e_in.p_x     = req.start_x;
      e_in.p_y     = req.start_y;
      e_in.q_x     = req.end_x;
      e_in.q_y     = req.end_y;
      e_in.rej     = (req.start_x < win_ff.left   && req.end_x < win_ff.left)  ||
                     (req.start_x > win_ff.right  && req.end_x > win_ff.right) ||
                     (req.start_y < win_ff.bottom && req.end_y < win_ff.bottom) ||
                     (req.start_y > win_ff.top    && req.end_y > win_ff.top);
      // Only the second end inside: the first end is the one that moves.
      e_in.swap     = ~p_in & q_in;
      e_in.in_x     = e_in.swap ? req.end_x : req.start_x;
      e_in.in_y     = e_in.swap ? req.end_y : req.start_y;
      e_in.out_x    = e_in.swap ? req.start_x : req.end_x;
      e_in.out_y    = e_in.swap ? req.start_y : req.end_y;
      e_in.act      = ~e_in.rej & ~(p_in & q_in);
      e_in.both_out = ~p_in & ~q_in;
   end

   logic     e_v_ff;
   item_type e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff <= e_in;
      end
   end

   // ---------------- first move: x cut, then y cut ----------------
   logic     x1_v, y1_v, x2_v, y2_v;
   item_type x1_item, y1_item, x2_item, y2_item;

   srcl_cut u_cut_x1 (
      .clock, .reset, .adv, .y_step(1'b0), .win(win_ff),
      .in_v(e_v_ff), .in_item(e_ff), .out_v(x1_v), .out_item(x1_item)
   );

   srcl_cut u_cut_y1 (
      .clock, .reset, .adv, .y_step(1'b1), .win(win_ff),
      .in_v(x1_v), .in_item(x1_item), .out_v(y1_v), .out_item(y1_item)
   );

   // ---------------- middle: second move when both ends were out ----------------
   item_type m_in;
   logic     moved_in, second;

   always_comb begin
      moved_in = is_inside(y1_item.out_x, y1_item.out_y, win_ff);
      second   = y1_item.act & y1_item.both_out & ~y1_item.rej;
      m_in     = y1_item;
      m_in.rej = y1_item.rej | (second & ~moved_in);
      m_in.act = second & moved_in;
      if (m_in.act) begin
         // The moved second end becomes the anchor for moving the first end.
         m_in.in_x  = y1_item.out_x;
         m_in.in_y  = y1_item.out_y;
         m_in.out_x = y1_item.in_x;
         m_in.out_y = y1_item.in_y;
         m_in.swap  = 1'b1;
      end
   end

   logic     m_v_ff;
   item_type m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= y1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
      end
   end

   srcl_cut u_cut_x2 (
      .clock, .reset, .adv, .y_step(1'b0), .win(win_ff),
      .in_v(m_v_ff), .in_item(m_ff), .out_v(x2_v), .out_item(x2_item)
   );

   srcl_cut u_cut_y2 (
      .clock, .reset, .adv, .y_step(1'b1), .win(win_ff),
      .in_v(x2_v), .in_item(x2_item), .out_v(y2_v), .out_item(y2_item)
   );

   // ---------------- output word ----------------
   rsp_word_type f_in;

   always_comb begin
      f_in.visible = ~y2_item.rej;
      if (y2_item.rej) begin
         f_in.clip_start_x = y2_item.p_x;
         f_in.clip_start_y = y2_item.p_y;
         f_in.clip_end_x   = y2_item.q_x;
         f_in.clip_end_y   = y2_item.q_y;
      end else if (y2_item.swap) begin
         f_in.clip_start_x = y2_item.out_x;
         f_in.clip_start_y = y2_item.out_y;
         f_in.clip_end_x   = y2_item.in_x;
         f_in.clip_end_y   = y2_item.in_y;
      end else begin
         f_in.clip_start_x = y2_item.in_x;
         f_in.clip_start_y = y2_item.in_y;
         f_in.clip_end_x   = y2_item.out_x;
         f_in.clip_end_y   = y2_item.out_y;
      end
   end

   logic         f_v_ff;
   rsp_word_type f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (adv) begin
         f_v_ff <= y2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   // ---------------- skid stage ----------------
   logic skid_v_in;

   always_comb begin
      if (skid_v_ff) begin
         skid_v_in = ~rsp.ready;
      end else begin
         skid_v_in = f_v_ff & ~rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_ff <= f_ff;
      end
   end

   rsp_word_type rsp_word;

   assign rsp_word         = skid_v_ff ? skid_ff : f_ff;
   assign rsp.valid        = skid_v_ff | f_v_ff;
   assign rsp.visible      = rsp_word.visible;
   assign rsp.clip_start_x = rsp_word.clip_start_x;
   assign rsp.clip_start_y = rsp_word.clip_start_y;
   assign rsp.clip_end_x   = rsp_word.clip_end_x;
   assign rsp.clip_end_y   = rsp_word.clip_end_y;

   // ---------------- assertions ----------------
   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp.ready |=> skid_v_ff && $stable(skid_ff))
      else $error("skid word dropped or changed while stalled");

   a_pipe_frozen : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(f_v_ff) && $stable(f_ff))
      else $error("output stage moved while the skid word was waiting");

   a_entry_loaded : assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> e_v_ff)
      else $error("accepted word did not enter the pipeline");

   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      !skid_v_ff && f_v_ff && !rsp.ready |=> skid_v_ff)
      else $error("stalled result not parked in the skid register");

endmodule

`default_nettype wire
